// ----- rtl/ldf_pkg.sv -----
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants for the length-prefixed deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned HDR_CNT_W    = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(4096);

  // Register indexes, taken from paddr[2]
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PASS   = 3'b010,
    PH_SKIP   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              frame_empty;
  } result_t;

endpackage

// ----- rtl/ldf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ldf_cfg_regs
// APB-style register file holding the maximum payload length.
// ----------------------------------------------------------------------------
module ldf_cfg_regs import ldf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  max_payload_o
);

  logic [LEN_W-1:0] max_payload_q;
  logic [LEN_W-1:0] max_payload_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    max_payload_d = max_payload_q;
    if (wr_en && (paddr[2] == REG_MAX_PAYLOAD)) begin
      max_payload_d = LEN_W'(pwdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else begin
      max_payload_q <= max_payload_d;
    end
  end

  // Unused locations read as zero
  assign prdata        = (paddr[2] == REG_MAX_PAYLOAD) ? DATA_W'(max_payload_q) : '0;
  assign max_payload_o = max_payload_q;

endmodule

// ----- rtl/ldf_parser.sv -----
// ----------------------------------------------------------------------------
// ldf_parser
// Header gathering, payload pass and skip control; one byte per cycle while take_i is high.
// ----------------------------------------------------------------------------
module ldf_parser import ldf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [BYTE_W-1:0] stream_byte_i,
  input  logic [LEN_W-1:0]  max_payload_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  phase_e                phase_q, phase_d;
  logic [HDR_CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [LEN_W-1:0]      len_shift_q, len_shift_d;
  logic [LEN_W-1:0]      bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0]      len_next;
  logic                  last_left;

  assign len_next  = {len_shift_q[LEN_W-BYTE_W-1:0], stream_byte_i};
  assign last_left = (bytes_left_q == LEN_W'(1));

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    len_shift_d  = len_shift_q;
    bytes_left_d = bytes_left_q;
    res_valid_o  = 1'b0;
    res_o        = '{payload_byte: stream_byte_i, frame_last: 1'b0, frame_empty: 1'b0};
    if (take_i) begin
      unique case (phase_q)
        PH_PASS: begin
          bytes_left_d      = bytes_left_q - LEN_W'(1);
          res_valid_o       = 1'b1;
          res_o.frame_last  = last_left;
          if (last_left) begin
            phase_d = PH_HEADER;
          end
        end
        PH_SKIP: begin
          bytes_left_d = bytes_left_q - LEN_W'(1);
          if (last_left) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          phase_d = PH_HEADER;
          if (hdr_cnt_q != HDR_LAST) begin
            hdr_cnt_d   = hdr_cnt_q + HDR_CNT_W'(1);
            len_shift_d = len_next;
          end else begin
            hdr_cnt_d   = '0;
            len_shift_d = '0;
            if (len_next == '0) begin
              res_valid_o = 1'b1;
              res_o       = '{payload_byte: '0, frame_last: 1'b1, frame_empty: 1'b1};
            end else begin
              bytes_left_d = len_next;
              phase_d      = (len_next > max_payload_i) ? PH_SKIP : PH_PASS;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      hdr_cnt_q    <= '0;
      len_shift_q  <= '0;
      bytes_left_q <= '0;
    end else begin
      phase_q      <= phase_d;
      hdr_cnt_q    <= hdr_cnt_d;
      len_shift_q  <= len_shift_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

// ----- rtl/ldf_out_buf.sv -----
// ----------------------------------------------------------------------------
// ldf_out_buf
// Result register with a skid stage behind it.
// ----------------------------------------------------------------------------
module ldf_out_buf import ldf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    load_out;

  assign load_out = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (load_out) begin
      // Drain the skid first; a push only arrives while the skid is empty
      out_valid_d  = skid_valid_q || push_i;
      out_d        = skid_valid_q ? skid_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/length_prefixed_deframer_core.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_deframer_core
// Splits a byte stream into messages with a 4-byte big-endian length prefix.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock while in_ready_o is high and
// registers its result, if any, in the output buffer. Header bytes and the
// payload of an oversized message (length above max_payload) give no result;
// every payload byte of an accepted message gives one result, the final one
// with frame_last set; a zero-length message gives a single result with
// frame_empty and frame_last set and payload_byte zero. The sustained rate is
// one byte per cycle: the parser updates its counters on every accepted byte
// and a result register plus one skid entry sit on the output, so in_ready_o
// drops only once both hold results that the sink has not taken. max_payload
// is sampled when a header completes; write it while the stream is idle.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_core import ldf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Stream input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] stream_byte_i,
  // Result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic              frame_last_o,
  output logic              frame_empty_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] max_payload;
  logic             take;
  logic             res_valid;
  result_t          res;
  result_t          out_data;

  // Accept a request whenever the skid entry is free
  assign take = in_valid_i && in_ready_o;

  ldf_cfg_regs u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_payload_o (max_payload)
  );

  ldf_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .stream_byte_i (stream_byte_i),
    .max_payload_i (max_payload),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  ldf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign payload_byte_o = out_data.payload_byte;
  assign frame_last_o   = out_data.frame_last;
  assign frame_empty_o  = out_data.frame_empty;

endmodule

// ----- rtl/ldf_checker.sv -----
// ----------------------------------------------------------------------------
// ldf_checker
// Port-level checks for the length-prefixed deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ldf_checker import ldf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] payload_byte_o,
  input logic              frame_last_o,
  input logic              frame_empty_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  // A held result must not vanish before the sink takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // Back pressure only when the output side is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // An empty-message result is always final and carries a zero byte
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_empty_o) |-> (frame_last_o && (payload_byte_o == '0)))
    else $error("malformed empty result");

  // A written max_payload reads back in the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD))
      |=> ((paddr[2] != REG_MAX_PAYLOAD) || (prdata == $past(pwdata))))
    else $error("max_payload readback mismatch");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind length_prefixed_deframer_core ldf_checker u_ldf_checker (.*);

// ----- dv/length_prefixed_deframer_core_tb.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_deframer_core_tb
// Self-checking bench for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
// Feeds the core a byte stream built from messages with a 4-byte big-endian
// length prefix and random payloads. A scoreboard tracks header, pass and skip
// state alongside the core and predicts every payload, last and empty result.
// The run covers empty messages, lengths on both sides of max_payload, both
// extremes of max_payload and a write to an unmapped register. Both sides
// idle in random bursts. The sink holds off once for a long stretch so the
// core backs up, and the source once waits for all results mid-phase.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_core_tb;
  import ldf_pkg::*;

  localparam int unsigned IDX_MAX_PAYLOAD = 0;
  localparam int unsigned IDX_UNMAPPED    = 1;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned SINK_HOLD       = 40;
  localparam int unsigned PHASE_REQUESTS  = 300;
  localparam int unsigned NUM_PHASES      = 6;

  // Tracks the deframer state and holds the results still owed by the core.
  class deframe_scoreboard;
    logic [LEN_W-1:0]     max_payload;
    phase_e               phase;
    logic [HDR_CNT_W-1:0] hdr_cnt;
    logic [LEN_W-1:0]     len_acc;
    logic [LEN_W-1:0]     bytes_left;
    result_t              expected_q[$];
    int unsigned          errors;

    function new();
      max_payload = MAX_PAYLOAD_RST;
      phase       = PH_HEADER;
      hdr_cnt     = '0;
      len_acc     = '0;
      bytes_left  = '0;
      errors      = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [DATA_W-1:0] value);
      if (idx == IDX_MAX_PAYLOAD) max_payload = value[LEN_W-1:0];
    endfunction

    function bit idle();
      return expected_q.size() == 0;
    endfunction

    // Advance the state by one accepted stream byte.
    function void note_request(logic [BYTE_W-1:0] b);
      result_t          r;
      logic [LEN_W-1:0] len;
      case (phase)
        PH_PASS: begin
          bytes_left     = bytes_left - 1;
          r.payload_byte = b;
          r.frame_last   = (bytes_left == 0);
          r.frame_empty  = 1'b0;
          expected_q.push_back(r);
          if (bytes_left == 0) phase = PH_HEADER;
        end
        PH_SKIP: begin
          bytes_left = bytes_left - 1;
          if (bytes_left == 0) phase = PH_HEADER;
        end
        default: begin
          phase = PH_HEADER;
          len   = {len_acc[LEN_W-BYTE_W-1:0], b};
          if (hdr_cnt != HDR_LAST) begin
            len_acc = len;
            hdr_cnt = hdr_cnt + 1'b1;
          end else begin
            hdr_cnt = '0;
            len_acc = '0;
            if (len == 0) begin
              r = '{payload_byte: '0, frame_last: 1'b1, frame_empty: 1'b1};
              expected_q.push_back(r);
            end else begin
              bytes_left = len;
              phase      = (len > max_payload) ? PH_SKIP : PH_PASS;
            end
          end
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: payload_byte %0h frame_last %0b frame_empty %0b",
               got.payload_byte, got.frame_last, got.frame_empty);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, actual %0b", want.frame_last, got.frame_last);
        errors++;
      end
      if (got.frame_empty !== want.frame_empty) begin
        $error("frame_empty: expected %0b, actual %0b", want.frame_empty, got.frame_empty);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] stream_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [BYTE_W-1:0] payload_byte_o;
  logic              frame_last_o;
  logic              frame_empty_o;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  deframe_scoreboard sb = new();

  // Idle burst odds shared by source and sink: one in idle_odds, zero for none.
  int unsigned idle_odds     = 4;
  int unsigned requests_sent = 0;
  bit          hold_sink     = 1'b0;

  length_prefixed_deframer_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sink: take results, idling in random bursts; hold off for a long stretch
  // when asked so the core fills up and drops in_ready_o.
  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check every result taken by the sink against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{payload_byte: payload_byte_o, frame_last: frame_last_o,
                        frame_empty: frame_empty_o});
    end
  end

  // Offer one stream byte, possibly after an idle burst, and hold it until taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(b);
    requests_sent++;
  endtask

  task automatic send_header(input logic [LEN_W-1:0] len);
    for (int i = HEADER_BYTES - 1; i >= 0; i--) send_byte(len[i*BYTE_W +: BYTE_W]);
  endtask

  // Mostly short messages, some empty, a few long, and some right on the
  // max_payload boundary so both the accept and the drop side are hit.
  task automatic send_random_message();
    int unsigned      pick;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 15);
    if (pick < 2) len = 0;
    else if (pick < 13) len = $urandom_range(1, 24);
    else if (pick < 15) len = $urandom_range(25, 300);
    else if (sb.max_payload < 300) len = sb.max_payload + $urandom_range(0, 1);
    else len = $urandom_range(1, 8);
    send_header(len);
    repeat (len) send_byte(BYTE_W'($urandom));
  endtask

  // Stop offering, wait for every owed result, then let the core settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (!sb.idle()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] limit;
    int unsigned       phase_end;
    bit                hold_done;
    bit                pause_done;

    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message and a one-byte message under the reset limit.
    send_header(0);
    send_header(1);
    send_byte(8'hFF);
    // Length equal to max_payload passes, one above it is dropped.
    drain_results();
    write_reg(IDX_MAX_PAYLOAD, 2);
    send_header(2);
    send_byte(8'h00);
    send_byte(8'h80);
    send_header(3);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);
    // Unmapped register: must leave max_payload at 2, so this one still passes.
    drain_results();
    write_reg(IDX_UNMAPPED, 0);
    send_header(1);
    send_byte(8'h5A);

    // Random phases over several limits, both extremes among them.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       limit = 32'hFFFF_FFFF;
        1:       limit = 32'd0;
        2:       limit = $urandom_range(1, 30);
        3:       limit = $urandom_range(31, 400);
        4:       limit = $urandom_range(0, 12);
        default: limit = $urandom_range(8, 60);
      endcase
      drain_results();
      write_reg(IDX_MAX_PAYLOAD, limit);
      // Last phase runs flat out on both sides.
      idle_odds = (p == NUM_PHASES - 1) ? 0 : $urandom_range(3, 10);
      phase_end = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        if (p == 0 && !hold_done && requests_sent + 200 > phase_end) begin
          hold_sink = 1'b1;
          hold_done = 1'b1;
        end
        if (p == 2 && !pause_done && requests_sent + 160 > phase_end) begin
          drain_results();
          pause_done = 1'b1;
        end
        send_random_message();
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
